FILE: hdl/bms_command_frame_builder_core_defines.svh
// Assertion helpers shared by the RTL files that carry checks.
`ifndef BMS_COMMAND_FRAME_BUILDER_CORE_DEFINES_SVH
`define BMS_COMMAND_FRAME_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked while reset is active.
`define BCFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and masked while reset is active.
`define BCFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bcfb_pkg.sv
package bcfb_pkg;

    // Frame header fields.
    localparam logic [7:0]  HDR_CMD_BIT  = 8'b1000_0000;
    localparam logic [3:0]  HDR_LEN_MASK = 4'b0111;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;

    // CRC-16/MODBUS, reflected form.
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

    // Byte positions of the fixed part of the frame.
    localparam logic [3:0] POS_HEADER  = 4'd0;
    localparam logic [3:0] POS_DEVICE  = 4'd1;
    localparam logic [3:0] POS_REG_HI  = 4'd2;
    localparam logic [3:0] POS_REG_LO  = 4'd3;
    localparam logic [3:0] POS_PAYLOAD = 4'd4;

    // Default depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified command as it travels through the queue.
    typedef struct packed {
        logic [7:0]  header;
        logic [7:0]  device_address;
        logic [15:0] register_address;
        logic [63:0] payload;
        logic [2:0]  len_code;
    } cmd_t;

    // Fold one byte into the running CRC, one bit per step.
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY_REFL;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

FILE: hdl/bcfb_front.sv
module bcfb_front (
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [6:0]        request_bits,
    input  logic [3:0]        payload_count,
    input  logic [7:0]        device_address,
    input  logic [15:0]       register_address,
    input  logic [63:0]       payload,
    input  logic              queue_full,
    output logic              push,
    output bcfb_pkg::cmd_t    cmd
);

    logic [3:0] count_minus_one;
    logic [2:0] len_code;

    // Length code wraps modulo 16 and keeps its low three bits.
    assign count_minus_one = payload_count - 4'd1;
    assign len_code        = 3'(count_minus_one & bcfb_pkg::HDR_LEN_MASK);

    // Take an item whenever the queue has room.
    assign cmd_ready = !queue_full;
    assign push      = cmd_valid && !queue_full;

    // Build the header byte and pack the command for the back end.
    always_comb
    begin
        cmd.header           = (bcfb_pkg::HDR_CMD_BIT | {1'b0, request_bits} | {5'b0, len_code})
                               & bcfb_pkg::BYTE_MASK;
        cmd.device_address   = device_address;
        cmd.register_address = register_address;
        cmd.payload          = payload;
        cmd.len_code         = len_code;
    end

endmodule

FILE: hdl/bcfb_queue.sv
`include "bms_command_frame_builder_core_defines.svh"

module bcfb_queue #(
    parameter int unsigned DEPTH = bcfb_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bcfb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output bcfb_pkg::cmd_t head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bcfb_pkg::cmd_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entries[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    `BCFB_ASSERT_NOW(a_no_overflow, push, !full, "queue written while full")
    `BCFB_ASSERT_NOW(a_no_underflow, pop, not_empty, "queue read while empty")
    `BCFB_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

FILE: hdl/bcfb_back.sv
`include "bms_command_frame_builder_core_defines.svh"

module bcfb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           queue_not_empty,
    input  bcfb_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           frame_valid,
    input  logic           frame_ready,
    output logic [7:0]     frame_byte,
    output logic           last_byte
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DATA   = 4'b0010,
        S_CRC_LO = 4'b0100,
        S_CRC_HI = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    bcfb_pkg::cmd_t cmd_reg, cmd_next;
    logic [3:0]     idx_reg, idx_next;
    logic [15:0]    crc_reg, crc_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_last_reg, out_last_next;

    logic           advance;
    logic [3:0]     data_end;
    logic [7:0]     data_byte;

    // The output register may be refilled when empty or being taken.
    assign advance  = !out_valid_reg || frame_ready;
    assign data_end = bcfb_pkg::POS_PAYLOAD + {1'b0, cmd_reg.len_code};

    // Pick the next data byte of the frame.
    always_comb
    begin
        case (idx_reg)
            bcfb_pkg::POS_HEADER: data_byte = cmd_reg.header;
            bcfb_pkg::POS_DEVICE: data_byte = cmd_reg.device_address;
            bcfb_pkg::POS_REG_HI: data_byte = cmd_reg.register_address[15:8];
            bcfb_pkg::POS_REG_LO: data_byte = cmd_reg.register_address[7:0];
            default:              data_byte = cmd_reg.payload[7:0];
        endcase
    end

    // Serializer: data bytes with running CRC, then CRC low and high.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (queue_not_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head_cmd;
                    idx_next   = bcfb_pkg::POS_HEADER;
                    crc_next   = bcfb_pkg::CRC_INIT;
                    state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_byte;
                    out_last_next  = 1'b0;
                    crc_next       = bcfb_pkg::crc_add_byte(crc_reg, data_byte);
                    idx_next       = idx_reg + 4'd1;
                    if (idx_reg >= bcfb_pkg::POS_PAYLOAD)
                    begin
                        cmd_next.payload = {8'h00, cmd_reg.payload[63:8]};
                    end
                    if (idx_reg == data_end)
                    begin
                        state_next = S_CRC_LO;
                    end
                end
            end
            S_CRC_LO:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[7:0];
                    out_last_next  = 1'b0;
                    state_next     = S_CRC_HI;
                end
            end
            S_CRC_HI:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[15:8];
                    out_last_next  = 1'b1;
                    // Start the next queued command right away.
                    if (queue_not_empty)
                    begin
                        pop        = 1'b1;
                        cmd_next   = head_cmd;
                        idx_next   = bcfb_pkg::POS_HEADER;
                        crc_next   = bcfb_pkg::CRC_INIT;
                        state_next = S_DATA;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign frame_valid = out_valid_reg;
    assign frame_byte  = out_byte_reg;
    assign last_byte   = out_last_reg;

    `BCFB_ASSERT_NOW(a_pop_at_frame_edge, pop,
        (state_reg == S_IDLE) || (state_reg == S_CRC_HI), "command taken mid-frame")
    `BCFB_ASSERT_NOW(a_idx_in_frame, state_reg == S_DATA,
        idx_reg <= data_end, "byte index ran past the payload")
    `BCFB_ASSERT_NEXT(a_crc_starts_fresh, pop,
        (crc_reg == bcfb_pkg::CRC_INIT) && (idx_reg == bcfb_pkg::POS_HEADER),
        "frame did not start from a fresh CRC")
    `BCFB_ASSERT_NEXT(a_last_ends_frame, (state_reg == S_CRC_HI) && advance,
        frame_valid && last_byte, "frame closed without last byte")

endmodule

FILE: hdl/bms_command_frame_builder_core.sv
// Command frame builder with CRC-16/MODBUS.
// Command channel: cmd_valid/cmd_ready with request_bits, payload_count,
// device_address, register_address and payload. Frame channel:
// frame_valid/frame_ready with frame_byte and last_byte, one byte per item.
// A frame is header, device address, register address high then low,
// 1 to 8 payload bytes and the CRC low byte then high byte, 7 to 14 bytes.
// Commands go into a small queue (QUEUE_DEPTH entries), so the command
// side keeps accepting while a frame is still being sent.
// The header byte is registered in the queue, the serializer's command
// register and the output register. One frame byte per cycle while
// frame_ready is high; a frame has 6 + n bytes (n payload bytes), and frames
// from queued commands follow each other with no gap.
// Reset clears the queue and the serializer; no byte is valid after reset.
// When the receiver holds frame_ready low, the current byte stays on the
// output and the serializer waits; once the queue fills, cmd_ready drops.
module bms_command_frame_builder_core #(
    parameter int unsigned QUEUE_DEPTH = bcfb_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [6:0]  request_bits,
    input  logic [3:0]  payload_count,
    input  logic [7:0]  device_address,
    input  logic [15:0] register_address,
    input  logic [63:0] payload,
    output logic        frame_valid,
    input  logic        frame_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_not_empty;
    bcfb_pkg::cmd_t push_cmd;
    bcfb_pkg::cmd_t head_cmd;

    bcfb_front u_front (
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .request_bits     (request_bits),
        .payload_count    (payload_count),
        .device_address   (device_address),
        .register_address (register_address),
        .payload          (payload),
        .queue_full       (queue_full),
        .push             (push),
        .cmd              (push_cmd)
    );

    bcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    bcfb_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .frame_valid     (frame_valid),
        .frame_ready     (frame_ready),
        .frame_byte      (frame_byte),
        .last_byte       (last_byte)
    );

endmodule

FILE: tb/tb_bms_command_frame_builder_core.sv
`timescale 1ns / 1ps

module tb_bms_command_frame_builder_core;

    // One command as presented on the command channel.
    typedef struct {
        logic [6:0]  request_bits;
        logic [3:0]  payload_count;
        logic [7:0]  device_address;
        logic [15:0] register_address;
        logic [63:0] payload;
    } command_t;

    // One frame byte as it should leave the block.
    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_beat_t;

    localparam int RANDOM_COMMANDS = 211;
    localparam int IDLE_LIMIT      = 4000;
    localparam int TAIL_CYCLES     = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [6:0]  request_bits = '0;
    logic [3:0]  payload_count = '0;
    logic [7:0]  device_address = '0;
    logic [15:0] register_address = '0;
    logic [63:0] payload = '0;
    logic        frame_valid;
    logic        frame_ready = 1'b0;
    logic [7:0]  frame_byte;
    logic        last_byte;

    command_t    pending_cmds[$];
    frame_beat_t expected_bytes[$];
    command_t    cmd_on_bus;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_phase;
    int          idle_cycles;
    int          mismatch_count;

    bms_command_frame_builder_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .request_bits     (request_bits),
        .payload_count    (payload_count),
        .device_address   (device_address),
        .register_address (register_address),
        .payload          (payload),
        .frame_valid      (frame_valid),
        .frame_ready      (frame_ready),
        .frame_byte       (frame_byte),
        .last_byte        (last_byte)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Build the whole frame for one command and queue its bytes.
    function automatic void predict_frame(input command_t c);
        logic [3:0]  count_minus_one;
        logic [2:0]  len_code;
        logic [7:0]  bytes [14];
        logic [15:0] crc;
        logic [63:0] pay;
        int          n;
        int          total;
        frame_beat_t beat;

        // The length code wraps modulo 16, so counts 0 and 9..15 still
        // produce a frame that agrees with its header.
        count_minus_one = c.payload_count - 4'd1;
        len_code = count_minus_one[2:0] & bcfb_pkg::HDR_LEN_MASK[2:0];
        n = int'(len_code) + 1;

        // Low request type bits overlap the length code on purpose.
        bytes[0] = bcfb_pkg::HDR_CMD_BIT | {1'b0, c.request_bits} | {5'b0, len_code};
        bytes[1] = c.device_address;
        bytes[2] = c.register_address[15:8];
        bytes[3] = c.register_address[7:0];
        pay = c.payload;
        for (int i = 0; i < n; i++)
        begin
            bytes[4 + i] = pay[7:0];
            pay = pay >> 8;
        end

        // Reflected CRC over header, address and payload bytes.
        crc = bcfb_pkg::CRC_INIT;
        for (int i = 0; i < 4 + n; i++)
        begin
            crc = crc ^ {8'h00, bytes[i]};
            for (int k = 0; k < 8; k++)
            begin
                if (crc[0])
                begin
                    crc = (crc >> 1) ^ bcfb_pkg::CRC_POLY_REFL;
                end
                else
                begin
                    crc = crc >> 1;
                end
            end
        end
        bytes[4 + n] = crc[7:0];
        bytes[5 + n] = crc[15:8];
        total = 6 + n;

        for (int i = 0; i < total; i++)
        begin
            beat.value = bytes[i];
            beat.last = (i == total - 1);
            expected_bytes.push_back(beat);
        end
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Block until no command is waiting or in flight and every frame byte is out.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Command driver: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                predict_frame(cmd_on_bus);
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd_on_bus = pending_cmds.pop_front();
                    request_bits <= cmd_on_bus.request_bits;
                    payload_count <= cmd_on_bus.payload_count;
                    device_address <= cmd_on_bus.device_address;
                    register_address <= cmd_on_bus.register_address;
                    payload <= cmd_on_bus.payload;
                    cmd_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // A quarter of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Frame receiver: drives frame_ready from one of four stall modes, picked at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ready <= 1'b0;
            stall_mode = 0;
            stall_phase = 0;
        end
        else
        begin
            stall_phase++;
            if (stall_phase % 50 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: frame_ready <= 1'b1;
                1: frame_ready <= ($urandom_range(0, 9) < 7);
                2: frame_ready <= (stall_phase % 4 == 0);
                default: frame_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Frame monitor: each accepted byte against the oldest expectation.
    always @(posedge clk)
    begin
        frame_beat_t beat;
        if (rst_n && frame_valid && frame_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                flag_error($sformatf("unexpected frame byte %02h last %0b",
                                     frame_byte, last_byte));
            end
            else
            begin
                beat = expected_bytes.pop_front();
                if (frame_byte !== beat.value)
                begin
                    flag_error($sformatf("frame_byte expected %02h, got %02h",
                                         beat.value, frame_byte));
                end
                if (last_byte !== beat.last)
                begin
                    flag_error($sformatf("last_byte expected %0b, got %0b",
                                         beat.last, last_byte));
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (frame_valid && frame_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus: directed commands, then random ones with a full drain midway.
    initial
    begin
        command_t c;
        int       r;

        mismatch_count = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Every count value, in and out of range, with field extremes.
        for (int i = 0; i < 16; i++)
        begin
            c.payload_count = 4'(i);
            c.request_bits = (i % 2 == 0) ? 7'h7F : 7'h00;
            c.device_address = (i % 2 == 0) ? 8'h00 : 8'hFF;
            c.register_address = (i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'h8001);
            c.payload = (i % 4 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                        ((i % 4 == 1) ? 64'h0 : 64'h0123_4567_89AB_CDEF);
            pending_cmds.push_back(c);
        end
        // Request type bits that collide with the length code.
        c.request_bits = 7'h07;
        c.payload_count = 4'd1;
        c.device_address = 8'h5A;
        c.register_address = 16'h00FF;
        c.payload = 64'hA5;
        pending_cmds.push_back(c);
        c.request_bits = 7'h05;
        c.payload_count = 4'd3;
        pending_cmds.push_back(c);
        c.request_bits = 7'h78;
        c.payload_count = 4'd8;
        c.payload = 64'h8000_0000_0000_0001;
        pending_cmds.push_back(c);
        wait_drained();

        for (int i = 0; i < RANDOM_COMMANDS; i++)
        begin
            if (i == RANDOM_COMMANDS / 2)
            begin
                wait_drained();
            end
            c.request_bits = 7'($urandom_range(0, 127));
            r = $urandom_range(0, 9);
            // Mostly legal counts; the rest are 9..15 and 0 (16 truncates to 0).
            c.payload_count = (r == 0) ? 4'($urandom_range(9, 16)) : 4'($urandom_range(1, 8));
            c.device_address = 8'($urandom);
            c.register_address = 16'($urandom);
            c.payload = {$urandom, $urandom};
            @(negedge clk);
            pending_cmds.push_back(c);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
